FILE: rtl/core/hlfe_pkg.sv
// hlfe_pkg: types, constants and the crc-16 fold shared by the hdlc-lite frame encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hlfe_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h8408;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic        need_open;
      logic [7:0]  data_byte;
      logic        frame_end;
      logic [15:0] fcs;
   } job_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] value);
      logic [15:0] c;
      c = crc ^ {8'h00, value};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hdlc_lite_frame_encoder_top.sv
// hdlc_lite_frame_encoder_top: top level of the hdlc-lite frame encoder
// depends on hlfe_pkg, hlfe_front, hlfe_job_queue, hlfe_back
`timescale 1ns / 1ps
`default_nettype none

// Byte-stuffing HDLC-like framer with FCS-16 (reflected poly 0x8408, init 0xFFFF).
// Push one payload byte per transfer with frame_end on the last byte of a frame;
// wire bytes come out of the rsp queue one per transfer, run_last marking the last
// byte caused by each input. The front end takes a byte every cycle while the job
// queue (QUEUE_DEPTH entries) has room; the back end emits one wire byte per cycle
// while a job waits and the rsp side is empty or popped. An input causes 1 wire byte
// if plain, 2 if escaped or an unescaped frame opener, up to 8 for a one-byte frame.
// csr_write_data sets fcs_invert (1 at reset: the FCS is complemented before it is sent).

module hdlc_lite_frame_encoder_top
   import hlfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data,
   input  wire logic    csr_write_en,
   input  wire logic    csr_write_data
);

   logic    queue_full;
   logic    job_push;
   job_type job_in;
   logic    job_valid;
   job_type job_head;
   logic    job_pop;

   hlfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .queue_full     (queue_full),
      .job_push       (job_push),
      .job_data       (job_in)
   );

   hlfe_job_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_in),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_data  (job_head)
   );

   hlfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_head),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/core/hlfe_front.sv
// hlfe_front: accepts payload bytes, tracks the open frame and the running crc,
// and hands a job record per byte to the back end. depends on hlfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module hlfe_front
   import hlfe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   input  wire logic    csr_write_en,
   input  wire logic    csr_write_data,
   input  wire logic    queue_full,
   output logic         job_push,
   output job_type      job_data
);

   logic [15:0] crc_ff, crc_in;
   logic        open_ff, open_in;
   logic        invert_ff, invert_in;
   logic        accept;
   logic [15:0] crc_base;
   logic [15:0] crc_new;

   assign accept   = req_push && !queue_full;
   assign req_full = queue_full;
   assign crc_base = open_ff ? crc_ff : CRC_INIT;
   assign crc_new  = crc_fold(crc_base, req_data.data_byte);

   always_comb begin
      crc_in    = crc_ff;
      open_in   = open_ff;
      invert_in = csr_write_en ? csr_write_data : invert_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            crc_in  = CRC_INIT;
            open_in = 1'b0;
         end else begin
            crc_in  = crc_new;
            open_in = 1'b1;
         end
      end
   end

   assign job_push           = accept;
   assign job_data.need_open = !open_ff;
   assign job_data.data_byte = req_data.data_byte;
   assign job_data.frame_end = req_data.frame_end;
   assign job_data.fcs       = crc_new ^ {16{invert_ff}};

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         open_ff   <= 1'b0;
         invert_ff <= 1'b1;
      end else begin
         crc_ff    <= crc_in;
         open_ff   <= open_in;
         invert_ff <= invert_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/hlfe_job_queue.sv
// hlfe_job_queue: short register fifo of job records between front and back end
// depends on hlfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module hlfe_job_queue
   import hlfe_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/hlfe_back.sv
// hlfe_back: walks each job through flag (if opening), stuffed data and, on frame_end, stuffed fcs
// and closing flag, one wire byte per cycle into the result register unless stalled. depends on hlfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module hlfe_back
   import hlfe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job_data,
   output logic         job_pop,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   localparam logic [2:0] PH_OPEN  = 3'd0;
   localparam logic [2:0] PH_DATA  = 3'd1;
   localparam logic [2:0] PH_FCSLO = 3'd2;
   localparam logic [2:0] PH_FCSHI = 3'd3;
   localparam logic [2:0] PH_CLOSE = 3'd4;

   logic [2:0] phase_ff, phase_in;
   logic       esc_ff, esc_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   logic [2:0] phase_now;
   logic [7:0] cur_byte;
   logic       stuffable;
   logic       needs_esc;
   logic       advance;
   logic       job_done;

   assign advance   = job_valid && (!out_valid_ff || rsp_pop);
   assign phase_now = (phase_ff == PH_OPEN && !job_data.need_open) ? PH_DATA : phase_ff;

   always_comb begin
      unique case (phase_now)
         PH_OPEN: begin
            cur_byte  = FLAG_BYTE;
            stuffable = 1'b0;
         end
         PH_DATA: begin
            cur_byte  = job_data.data_byte;
            stuffable = 1'b1;
         end
         PH_FCSLO: begin
            cur_byte  = job_data.fcs[7:0];
            stuffable = 1'b1;
         end
         PH_FCSHI: begin
            cur_byte  = job_data.fcs[15:8];
            stuffable = 1'b1;
         end
         default: begin
            cur_byte  = FLAG_BYTE;
            stuffable = 1'b0;
         end
      endcase
   end

   assign needs_esc = stuffable && (cur_byte == FLAG_BYTE || cur_byte == ESC_BYTE);

   always_comb begin
      phase_in     = phase_ff;
      esc_in       = esc_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      job_done     = 1'b0;
      if (advance) begin
         out_valid_in = 1'b1;
         if (needs_esc && !esc_ff) begin
            out_in.tx_byte  = ESC_BYTE;
            out_in.run_last = 1'b0;
            esc_in          = 1'b1;
            phase_in        = phase_now;
         end else begin
            out_in.tx_byte = needs_esc ? (cur_byte ^ ESC_XOR) : cur_byte;
            esc_in         = 1'b0;
            unique case (phase_now)
               PH_OPEN:  phase_in = PH_DATA;
               PH_DATA: begin
                  if (job_data.frame_end) begin
                     phase_in = PH_FCSLO;
                  end else begin
                     job_done = 1'b1;
                  end
               end
               PH_FCSLO: phase_in = PH_FCSHI;
               PH_FCSHI: phase_in = PH_CLOSE;
               default:  job_done = 1'b1;
            endcase
            if (job_done) begin
               phase_in = PH_OPEN;
            end
            out_in.run_last = job_done;
         end
      end
   end

   assign job_pop   = job_done;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPEN;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         esc_ff       <= esc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire
